[rtl/lrrb_pkg.sv]
// Shared types and constants for the line receive ring buffer.
// No dependencies; every other file of the block imports this package.
package lrrb_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 6;

	localparam logic [BYTE_W-1:0] TERM_RESET = 8'd10;

	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		ST_STORED  = 2'd0,
		ST_DROPPED = 2'd1,
		ST_DRAINED = 2'd2,
		ST_REFUSED = 2'd3
	} status_t;

	typedef struct packed {
		logic              command;
		logic [BYTE_W-1:0] rx_byte;
	} request_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic [IDX_W-1:0]  byte_index;
		logic              last;
		status_t           status;
		logic              message_ready;
	} result_t;

endpackage

[rtl/lrrb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on lrrb_pkg for default sizes only.
module lrrb_ram
	import lrrb_pkg::*;
#(
	parameter int WIDTH = BYTE_W,
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/lrrb_ctrl.sv]
// Ring control: pointers, line-ready flag, drain sequencer and result register.
// Depends on lrrb_pkg; drives the write and read ports of one lrrb_ram.
module lrrb_ctrl
	import lrrb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  request_t                 request,
	input  logic [BYTE_W-1:0]        terminator,
	output logic                     busy,
	output logic                     strobe,
	output result_t                  result,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output logic [BYTE_W-1:0]        ram_wdata,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	input  logic [BYTE_W-1:0]        ram_rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

	typedef enum logic {
		S_IDLE,
		S_DRAIN
	} state_t;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == LastAddr) ? '0 : p + AW'(1);
	endfunction

	state_t           state_q;
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic             ready_q;
	logic [IDX_W-1:0] idx_q;
	logic             pend_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             strobe_q;
	result_t          res_q;

	logic          accept;
	logic          is_byte;
	logic [AW-1:0] wr_next;
	logic [AW-1:0] rd_next;
	logic [AW-1:0] newest;
	logic          full;
	logic          ready_after_byte;

	assign busy    = (state_q == S_DRAIN) || pend_s1;
	assign accept  = start && !busy;
	assign is_byte = (request.command == CMD_BYTE);
	assign wr_next = next_ptr(wr_ptr_q);
	assign rd_next = next_ptr(rd_ptr_q);
	assign newest  = (wr_ptr_q == '0) ? LastAddr : wr_ptr_q - AW'(1);
	assign full    = (wr_next == rd_ptr_q);
	assign ready_after_byte = ready_q || (request.rx_byte == terminator);

	// On overflow, overwrite the newest byte with the terminator.
	assign ram_we    = accept && is_byte;
	assign ram_waddr = full ? newest : wr_ptr_q;
	assign ram_wdata = full ? terminator : request.rx_byte;
	assign ram_raddr = rd_ptr_q;

	assign strobe = strobe_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			ready_q  <= 1'b0;
			idx_q    <= '0;
			pend_s1  <= 1'b0;
			last_s1  <= 1'b0;
			idx_s1   <= '0;
			strobe_q <= 1'b0;
			res_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			pend_s1  <= 1'b0;

			// Read data of the previous drain step is valid now.
			if (pend_s1) begin
				strobe_q            <= 1'b1;
				res_q.data_byte     <= ram_rdata;
				res_q.byte_index    <= idx_s1;
				res_q.last          <= last_s1;
				res_q.status        <= ST_DRAINED;
				res_q.message_ready <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q.data_byte  <= '0;
						res_q.byte_index <= '0;
						res_q.last       <= 1'b1;
						if (is_byte) begin
							strobe_q <= 1'b1;
							if (full) begin
								ready_q             <= 1'b1;
								res_q.status        <= ST_DROPPED;
								res_q.message_ready <= 1'b1;
							end else begin
								wr_ptr_q            <= wr_next;
								ready_q             <= ready_after_byte;
								res_q.status        <= ST_STORED;
								res_q.message_ready <= ready_after_byte;
							end
						end else if (!ready_q || (rd_ptr_q == wr_ptr_q)) begin
							strobe_q            <= 1'b1;
							ready_q             <= 1'b0;
							res_q.status        <= ST_REFUSED;
							res_q.message_ready <= 1'b0;
						end else begin
							ready_q <= 1'b0;
							idx_q   <= '0;
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					pend_s1  <= 1'b1;
					idx_s1   <= idx_q;
					last_s1  <= (rd_next == wr_ptr_q);
					rd_ptr_q <= rd_next;
					idx_q    <= idx_q + IDX_W'(1);
					if (rd_next == wr_ptr_q) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/line_receive_ring_buffer_core.sv]
// Line receive ring buffer top level: terminator register, control and byte RAM.
// Byte beat: result strobes the cycle after acceptance; busy stays low, one beat a cycle.
// Drain of N bytes: busy through the drain and its last read in flight; results one a
// cycle, paced by the single registered read port of the byte RAM. A refused drain
// answers like a byte beat. Reset (arst_n low) empties the ring, clears the ready flag
// and sets the terminator to newline; the receiver cannot stall and takes every strobe.
module line_receive_ring_buffer_core
	import lrrb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  request_t          request,
	output logic              strobe,
	output result_t           result,
	input  logic              cfg_we,
	input  logic [BYTE_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(DEPTH);

	// Terminator register: the user must write it only while idle, so no hazard with a beat in flight; not enforced here.
	logic [BYTE_W-1:0] term_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= TERM_RESET;
		end else if (cfg_we) begin
			term_q <= cfg_wdata;
		end
	end

	// RAM port signals between the control and the byte store.
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// Control: holds pointers and flag, writes arriving bytes straight into the RAM at
	// the accepting edge, and steps the drain one read address a cycle. Busy covers the
	// drain plus the last read in flight, so a new beat never collides with a drained one.
	lrrb_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.request    (request),
		.terminator (term_q),
		.busy       (busy),
		.strobe     (strobe),
		.result     (result),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	// Byte store: contents undefined until written; only written entries are drained.
	lrrb_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[tb/line_receive_ring_buffer_core_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for line_receive_ring_buffer_core: a directed table, then random line traffic.
// Depends on lrrb_pkg and the core; tracks the ring, the ready flag and the terminator on its own.
module line_receive_ring_buffer_core_test;
	import lrrb_pkg::*;

	localparam int RING_DEPTH  = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 30;

	// One row of stimulus; reps repeats the beat, pinned marks a typed-in expectation.
	typedef struct {
		request_t    req;
		int unsigned reps;
		logic        pinned;
		result_t     want;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	request_t          request;
	logic              strobe;
	result_t           result;
	logic              cfg_we;
	logic [BYTE_W-1:0] cfg_wdata;

	// Typed-in expectation travelling alongside the request being offered.
	logic              pin_now;
	result_t           pin_want;

	// Shadow of the ring, its pointers, the ready flag and the terminator register.
	logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
	int unsigned       head = 0;
	int unsigned       tail = 0;
	logic              line_waiting = 1'b0;
	logic [BYTE_W-1:0] term_byte = TERM_RESET;

	result_t           expected_beats [$];
	stim_row_t         script [$];
	stim_row_t         plan [$];
	int                failures = 0;
	int unsigned       cycle_count = 0;

	line_receive_ring_buffer_core #(
		.DEPTH(RING_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.strobe   (strobe),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t beat(logic [BYTE_W-1:0] data, logic [IDX_W-1:0] idx,
			logic last, status_t st, logic ready);
		result_t r;
		r.data_byte     = data;
		r.byte_index    = idx;
		r.last          = last;
		r.status        = st;
		r.message_ready = ready;
		return r;
	endfunction

	function automatic stim_row_t row(logic cmd, logic [BYTE_W-1:0] b, int unsigned reps,
			logic pinned, result_t want);
		stim_row_t r;
		r.req.command = cmd;
		r.req.rx_byte = b;
		r.reps        = reps;
		r.pinned      = pinned;
		r.want        = want;
		return r;
	endfunction

	// Work out every beat that one accepted request produces and queue them in order.
	function automatic void line_frame_beats(request_t req);
		int unsigned       n;
		logic [BYTE_W-1:0] data;
		n = 0;
		if (req.command == CMD_BYTE) begin
			if ((head + 1) % RING_DEPTH != tail) begin
				ring_bytes[head] = req.rx_byte;
				head = (head + 1) % RING_DEPTH;
				if (req.rx_byte == term_byte)
					line_waiting = 1'b1;
				expected_beats.push_back(beat('0, '0, 1'b1, ST_STORED, line_waiting));
			end else begin
				// Full ring: drop the byte and close the line on the newest stored byte.
				ring_bytes[(head + RING_DEPTH - 1) % RING_DEPTH] = term_byte;
				line_waiting = 1'b1;
				expected_beats.push_back(beat('0, '0, 1'b1, ST_DROPPED, 1'b1));
			end
		end else if (!line_waiting) begin
			expected_beats.push_back(beat('0, '0, 1'b1, ST_REFUSED, 1'b0));
		end else begin
			line_waiting = 1'b0;
			if (tail == head)
				expected_beats.push_back(beat('0, '0, 1'b1, ST_REFUSED, 1'b0));
			// Empty the whole ring, oldest first, which may run into the next line.
			while (tail != head) begin
				data = ring_bytes[tail];
				tail = (tail + 1) % RING_DEPTH;
				expected_beats.push_back(beat(data, n[IDX_W-1:0], tail == head,
					ST_DRAINED, 1'b0));
				n++;
			end
		end
	endfunction

	task automatic check_beat(result_t got);
		result_t want;
		if (expected_beats.size() == 0) begin
			$error("unexpected result beat: status %0d data_byte %0h",
				got.status, got.data_byte);
			failures++;
		end else begin
			want = expected_beats.pop_front();
			if (got.data_byte !== want.data_byte) begin
				$error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
				failures++;
			end
			if (got.byte_index !== want.byte_index) begin
				$error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
				failures++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				failures++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failures++;
			end
			if (got.message_ready !== want.message_ready) begin
				$error("message_ready: expected %0b, got %0b", want.message_ready,
					got.message_ready);
				failures++;
			end
		end
	endtask

	// Sample at the rising edge: check the beat on the result port first, then
	// predict for a request taken at this edge, then track a register write.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			tail = 0;
			line_waiting = 1'b0;
			term_byte = TERM_RESET;
			expected_beats.delete();
		end else begin
			if (strobe)
				check_beat(result);
			if (start && !busy) begin
				line_frame_beats(request);
				// A typed-in row replaces the prediction for its single beat.
				if (pin_now)
					expected_beats[expected_beats.size() - 1] = pin_want;
			end
			if (cfg_we)
				term_byte = cfg_wdata;
		end
	end

	// Hard stop on a hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [BYTE_W-1:0] plain_byte(logic [BYTE_W-1:0] term);
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(0, 255));
		if (b == term)
			b ^= 8'h01;
		return b;
	endfunction

	function automatic void push_beat(logic cmd, logic [BYTE_W-1:0] b);
		plan.push_back(row(cmd, b, 1, 1'b0, beat('0, '0, 1'b0, ST_STORED, 1'b0)));
	endfunction

	// Build one phase of random traffic: mostly framed lines with random content,
	// some lines long enough to overflow, the rest stray drains, loose bytes and cut-off lines.
	task automatic plan_random(int unsigned quota, logic [BYTE_W-1:0] term);
		int unsigned base;
		int unsigned pick;
		base = plan.size();
		while (plan.size() - base < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				repeat ($urandom_range(0, 8)) push_beat(CMD_BYTE, plain_byte(term));
				push_beat(CMD_BYTE, term);
				// Now and then let the next line begin before the host drains.
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) push_beat(CMD_BYTE, plain_byte(term));
				push_beat(CMD_DRAIN, BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 62) begin
				repeat ($urandom_range(58, 68)) push_beat(CMD_BYTE, plain_byte(term));
				push_beat(CMD_DRAIN, BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 75) begin
				push_beat(CMD_DRAIN, BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) push_beat(CMD_BYTE, BYTE_W'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6)) push_beat(CMD_BYTE, plain_byte(term));
			end
		end
	endtask

	// Offer the plan in bursts of random length with random gaps; hold start high
	// across a burst and drop it only for a gap, scrambling the payload meanwhile.
	task automatic drive_plan();
		stim_row_t   item;
		int unsigned burst;
		int unsigned gap;
		while (plan.size() != 0) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
			while (burst != 0 && plan.size() != 0) begin
				item = plan.pop_front();
				@(negedge clk);
				start    <= 1'b1;
				request  <= item.req;
				pin_now  <= item.pinned;
				pin_want <= item.want;
				do @(posedge clk); while (busy);
				burst--;
			end
			if (gap != 0) begin
				@(negedge clk);
				start           <= 1'b0;
				pin_now         <= 1'b0;
				request.command <= 1'($urandom_range(0, 1));
				request.rx_byte <= BYTE_W'($urandom_range(0, 255));
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		start   <= 1'b0;
		pin_now <= 1'b0;
	endtask

	// Write the terminator only once the block has gone quiet.
	task automatic set_terminator(logic [BYTE_W-1:0] value);
		while (expected_beats.size() != 0 || busy) @(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		stim_row_t   entry;
		int unsigned k;
		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		pin_now   = 1'b0;
		pin_want  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table, terminator at its reset value (newline).
		script.push_back(row(CMD_DRAIN, 8'hA5, 1, 1'b1, beat('0, '0, 1'b1, ST_REFUSED, 1'b0)));
		script.push_back(row(CMD_BYTE, 8'h00, 1, 1'b1, beat('0, '0, 1'b1, ST_STORED, 1'b0)));
		script.push_back(row(CMD_BYTE, 8'hFF, 1, 1'b1, beat('0, '0, 1'b1, ST_STORED, 1'b0)));
		script.push_back(row(CMD_BYTE, 8'h5A, 1, 1'b0, '0));
		script.push_back(row(CMD_BYTE, TERM_RESET, 1, 1'b1,
			beat('0, '0, 1'b1, ST_STORED, 1'b1)));
		// A byte after the terminator opens the next line and keeps the flag up.
		script.push_back(row(CMD_BYTE, 8'hA5, 1, 1'b1, beat('0, '0, 1'b1, ST_STORED, 1'b1)));
		script.push_back(row(CMD_DRAIN, 8'h00, 1, 1'b0, '0));
		script.push_back(row(CMD_DRAIN, 8'hFF, 1, 1'b1, beat('0, '0, 1'b1, ST_REFUSED, 1'b0)));
		// A line that is nothing but the terminator.
		script.push_back(row(CMD_BYTE, TERM_RESET, 1, 1'b1,
			beat('0, '0, 1'b1, ST_STORED, 1'b1)));
		script.push_back(row(CMD_DRAIN, 8'h00, 1, 1'b1,
			beat(TERM_RESET, '0, 1'b1, ST_DRAINED, 1'b0)));
		// Fill to capacity, then overflow twice: drop and close the line.
		script.push_back(row(CMD_BYTE, 8'h33, RING_DEPTH - 1, 1'b0, '0));
		script.push_back(row(CMD_BYTE, 8'h77, 1, 1'b1, beat('0, '0, 1'b1, ST_DROPPED, 1'b1)));
		script.push_back(row(CMD_BYTE, 8'h78, 1, 1'b1, beat('0, '0, 1'b1, ST_DROPPED, 1'b1)));
		script.push_back(row(CMD_DRAIN, 8'h00, 1, 1'b0, '0));
		script.push_back(row(CMD_DRAIN, 8'h00, 1, 1'b1, beat('0, '0, 1'b1, ST_REFUSED, 1'b0)));

		foreach (script[i]) begin
			entry = script[i];
			for (k = 0; k < script[i].reps; k++)
				plan.push_back(entry);
		end
		drive_plan();

		// Random phases across the terminator's range, extremes first, newline last.
		set_terminator(8'h00);
		plan_random(PHASE_ITEMS, 8'h00);
		drive_plan();
		set_terminator(8'hFF);
		plan_random(PHASE_ITEMS, 8'hFF);
		drive_plan();
		entry.req.rx_byte = BYTE_W'($urandom_range(1, 254));
		set_terminator(entry.req.rx_byte);
		plan_random(PHASE_ITEMS, entry.req.rx_byte);
		drive_plan();
		set_terminator(TERM_RESET);
		plan_random(PHASE_ITEMS, TERM_RESET);
		drive_plan();

		// Drain the expectations, then watch a full drain's length for stray beats.
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (RING_DEPTH + 4) @(posedge clk);
		if (expected_beats.size() != 0) begin
			$error("%0d expected beats never arrived", expected_beats.size());
			failures++;
		end
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/lrrb_pkg.sv
rtl/lrrb_ram.sv
rtl/lrrb_ctrl.sv
rtl/line_receive_ring_buffer_core.sv
tb/line_receive_ring_buffer_core_test.sv
